[src/ps2kbt_pkg.sv]
package ps2kbt_pkg;

  localparam int MAX_SLOTS    = 8;
  localparam int NUM_BINDINGS = 8;
  localparam int CODES_W      = 8 * MAX_SLOTS;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = CODES_W;

  localparam logic [7:0] BREAK_PREFIX = 8'hF0;
  localparam logic [7:0] EXT_PREFIX   = 8'hE0;
  localparam logic [3:0] NO_SLOT      = 4'd8;

  localparam logic [CODES_W-1:0]   CODES_RESET = 64'h746B7275231C1B1D;
  localparam logic [MAX_SLOTS-1:0] EXT_RESET   = 8'hF0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CODES = 2'd0,
    CFG_EXT   = 2'd1
  } cfg_reg_t;

  typedef enum logic [2:0] {
    EV_NONE         = 3'd0,
    EV_BREAK_PREFIX = 3'd1,
    EV_EXT_PREFIX   = 3'd2,
    EV_MAKE         = 3'd3,
    EV_BREAK        = 3'd4
  } event_kind_t;

  typedef struct packed {
    logic                 break_pending;
    logic                 extended_pending;
    logic [MAX_SLOTS-1:0] held;
  } key_state_t;

  typedef struct packed {
    logic [3:0]           slot;
    logic [MAX_SLOTS-1:0] onehot;
  } match_t;

  typedef struct packed {
    logic [7:0]           last_byte;
    event_kind_t          kind;
    logic [3:0]           slot;
    logic [MAX_SLOTS-1:0] held;
  } result_t;

endpackage

[src/ps2kbt_match.sv]
module ps2kbt_match (
  input  logic [ps2kbt_pkg::CODES_W-1:0]   codes,
  input  logic [ps2kbt_pkg::MAX_SLOTS-1:0] ext_bits,
  input  logic                             ext_pending,
  input  logic [7:0]                       code,
  output ps2kbt_pkg::match_t               match
);

  logic [ps2kbt_pkg::MAX_SLOTS-1:0] hit;

  always_comb begin
    for (int k = 0; k < ps2kbt_pkg::MAX_SLOTS; k++) begin
      hit[k] = (k < ps2kbt_pkg::NUM_BINDINGS) && (codes[8*k +: 8] == code) &&
               (ext_bits[k] == ext_pending);
    end
  end

  // lowest matching slot wins
  always_comb begin
    match.slot   = ps2kbt_pkg::NO_SLOT;
    match.onehot = hit & (~hit + 1'b1);
    for (int k = ps2kbt_pkg::MAX_SLOTS - 1; k >= 0; k--) begin
      if (hit[k]) begin
        match.slot = 4'(k);
      end
    end
  end

endmodule

[src/ps2kbt_decode.sv]
module ps2kbt_decode (
  input  logic                             byte_valid,
  input  logic [7:0]                       scan_byte,
  input  ps2kbt_pkg::key_state_t           st,
  input  logic [ps2kbt_pkg::CODES_W-1:0]   codes,
  input  logic [ps2kbt_pkg::MAX_SLOTS-1:0] ext_bits,
  output ps2kbt_pkg::key_state_t           st_nxt,
  output ps2kbt_pkg::result_t              res
);

  ps2kbt_pkg::match_t match;

  ps2kbt_match u_match (
    .codes       (codes),
    .ext_bits    (ext_bits),
    .ext_pending (st.extended_pending),
    .code        (scan_byte),
    .match       (match)
  );

  always_comb begin
    st_nxt        = st;
    res.last_byte = scan_byte;
    res.kind      = ps2kbt_pkg::EV_NONE;
    res.slot      = ps2kbt_pkg::NO_SLOT;
    if (!byte_valid) begin
      res.last_byte = 8'd0;
    end else if (scan_byte == ps2kbt_pkg::BREAK_PREFIX) begin
      st_nxt.break_pending = 1'b1;
      res.kind             = ps2kbt_pkg::EV_BREAK_PREFIX;
    end else if (st.break_pending) begin
      st_nxt.held             = st.held & ~match.onehot;
      st_nxt.break_pending    = 1'b0;
      st_nxt.extended_pending = 1'b0;
      res.kind                = ps2kbt_pkg::EV_BREAK;
      res.slot                = match.slot;
    end else if (scan_byte == ps2kbt_pkg::EXT_PREFIX) begin
      st_nxt.extended_pending = 1'b1;
      res.kind                = ps2kbt_pkg::EV_EXT_PREFIX;
    end else begin
      st_nxt.held             = st.held | match.onehot;
      st_nxt.break_pending    = 1'b0;
      st_nxt.extended_pending = 1'b0;
      res.kind                = ps2kbt_pkg::EV_MAKE;
      res.slot                = match.slot;
    end
    res.held = st_nxt.held;
  end

endmodule

[src/ps2_key_binding_tracker_top.sv]
// PS/2 set 2 key binding tracker: takes one received byte per transaction and returns one
// result per transaction (byte echo, event kind, matched binding slot, held mask). A new
// byte is accepted every cycle while out_ready stays high. A byte is held in the input
// register, and its result is loaded into the result register when the byte advances, where
// the prefix flags, the held bits and the parallel compare against all eight bindings are
// resolved in a single pass. While a result waits on out_ready, a byte in the input
// register holds there and in_ready drops. Bindings reset to the default key set and may be
// rewritten through the cfg port while no transaction is in flight.
module ps2_key_binding_tracker_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_byte_valid,
  input  logic [7:0]                          in_scan_byte,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [7:0]                          out_last_byte,
  output logic [2:0]                          out_event_kind,
  output logic [3:0]                          out_matched_slot,
  output logic [7:0]                          out_held_mask,
  input  logic                                cfg_we,
  input  logic [ps2kbt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ps2kbt_pkg::CFG_DATA_W-1:0]   cfg_data
);

  logic                             s1_valid_r;
  logic                             s1_byte_valid_r;
  logic [7:0]                       s1_scan_byte_r;
  logic                             s1_advance;
  logic                             out_valid_r;
  ps2kbt_pkg::result_t              out_res_r;
  ps2kbt_pkg::result_t              res;
  ps2kbt_pkg::key_state_t           st_r;
  ps2kbt_pkg::key_state_t           st_nxt;
  logic [ps2kbt_pkg::CODES_W-1:0]   codes_r;
  logic [ps2kbt_pkg::MAX_SLOTS-1:0] ext_r;

  assign s1_advance = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready   = !s1_valid_r || s1_advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codes_r <= ps2kbt_pkg::CODES_RESET;
      ext_r   <= ps2kbt_pkg::EXT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ps2kbt_pkg::CFG_CODES: codes_r <= cfg_data;
        ps2kbt_pkg::CFG_EXT:   ext_r   <= cfg_data[ps2kbt_pkg::MAX_SLOTS-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_valid_r <= in_byte_valid;
      s1_scan_byte_r  <= in_scan_byte;
    end
  end

  ps2kbt_decode u_decode (
    .byte_valid (s1_byte_valid_r),
    .scan_byte  (s1_scan_byte_r),
    .st         (st_r),
    .codes      (codes_r),
    .ext_bits   (ext_r),
    .st_nxt     (st_nxt),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (s1_advance) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_res_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_last_byte    = out_res_r.last_byte;
  assign out_event_kind   = out_res_r.kind;
  assign out_matched_slot = out_res_r.slot;
  assign out_held_mask    = out_res_r.held;

`ifndef SYNTHESIS
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("input stalled with empty result register");

  a_make_sets_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.kind == ps2kbt_pkg::EV_MAKE &&
    out_res_r.slot != ps2kbt_pkg::NO_SLOT |-> out_res_r.held[out_res_r.slot[2:0]])
    else $error("make did not set held bit");

  a_break_clears_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.kind == ps2kbt_pkg::EV_BREAK &&
    out_res_r.slot != ps2kbt_pkg::NO_SLOT |-> !out_res_r.held[out_res_r.slot[2:0]])
    else $error("break did not clear held bit");

  a_prefix_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_res_r.kind == ps2kbt_pkg::EV_BREAK_PREFIX ||
    out_res_r.kind == ps2kbt_pkg::EV_EXT_PREFIX || out_res_r.kind == ps2kbt_pkg::EV_NONE)
    |-> out_res_r.slot == ps2kbt_pkg::NO_SLOT)
    else $error("slot reported for non-key event");

  a_f0_arms_break: assert property (@(posedge clk) disable iff (!rst_n)
    s1_advance && s1_byte_valid_r && s1_scan_byte_r == ps2kbt_pkg::BREAK_PREFIX
    |=> st_r.break_pending)
    else $error("break prefix not armed");
`endif

endmodule

[tb/tb_ps2_key_binding_tracker_top.sv]
`timescale 1ns / 1ps

module tb_ps2_key_binding_tracker_top;

  localparam logic [ps2kbt_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [ps2kbt_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef struct packed {
    logic       present;
    logic [7:0] code;
  } key_byte_t;

  logic                              clk;
  logic                              rst_n            = 1'b0;
  logic                              in_valid         = 1'b0;
  logic                              in_ready;
  logic                              in_byte_valid    = 1'b0;
  logic [7:0]                        in_scan_byte     = 8'h00;
  logic                              out_valid;
  logic                              out_ready        = 1'b0;
  logic [7:0]                        out_last_byte;
  logic [2:0]                        out_event_kind;
  logic [3:0]                        out_matched_slot;
  logic [7:0]                        out_held_mask;
  logic                              cfg_we           = 1'b0;
  logic [ps2kbt_pkg::CFG_IDX_W-1:0]  cfg_index        = ps2kbt_pkg::CFG_CODES;
  logic [ps2kbt_pkg::CFG_DATA_W-1:0] cfg_data         = '0;

  key_byte_t           byte_queue[$];
  ps2kbt_pkg::result_t key_events_due[$];
  int                  mismatch_count = 0;

  // mirror of the tracker state and bindings
  logic [ps2kbt_pkg::CODES_W-1:0]   bind_codes = ps2kbt_pkg::CODES_RESET;
  logic [ps2kbt_pkg::MAX_SLOTS-1:0] bind_ext   = ps2kbt_pkg::EXT_RESET;
  logic                             brk_armed  = 1'b0;
  logic                             ext_armed  = 1'b0;
  logic [ps2kbt_pkg::MAX_SLOTS-1:0] held_keys  = '0;

  int unsigned in_gap   = 0;
  int unsigned out_gap  = 0;
  bit          in_calm  = 1'b0;
  bit          out_calm = 1'b0;

  ps2_key_binding_tracker_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_byte_valid    (in_byte_valid),
    .in_scan_byte     (in_scan_byte),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_last_byte    (out_last_byte),
    .out_event_kind   (out_event_kind),
    .out_matched_slot (out_matched_slot),
    .out_held_mask    (out_held_mask),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [3:0] lookup_binding(input logic [7:0] code);
    for (int k = 0; k < ps2kbt_pkg::NUM_BINDINGS; k++) begin
      if (bind_codes[8*k +: 8] == code && bind_ext[k] == ext_armed) return 4'(k);
    end
    return ps2kbt_pkg::NO_SLOT;
  endfunction

  function automatic ps2kbt_pkg::result_t decode_key_byte(input logic present,
                                                          input logic [7:0] code);
    ps2kbt_pkg::result_t r;
    r.last_byte = code;
    r.kind      = ps2kbt_pkg::EV_NONE;
    r.slot      = ps2kbt_pkg::NO_SLOT;
    if (!present) begin
      r.last_byte = 8'h00;
    end else if (code == ps2kbt_pkg::BREAK_PREFIX) begin
      brk_armed = 1'b1;
      r.kind    = ps2kbt_pkg::EV_BREAK_PREFIX;
    end else if (brk_armed) begin
      r.slot = lookup_binding(code);
      if (r.slot != ps2kbt_pkg::NO_SLOT) held_keys[r.slot[2:0]] = 1'b0;
      brk_armed = 1'b0;
      ext_armed = 1'b0;
      r.kind    = ps2kbt_pkg::EV_BREAK;
    end else if (code == ps2kbt_pkg::EXT_PREFIX) begin
      ext_armed = 1'b1;
      r.kind    = ps2kbt_pkg::EV_EXT_PREFIX;
    end else begin
      r.slot = lookup_binding(code);
      if (r.slot != ps2kbt_pkg::NO_SLOT) held_keys[r.slot[2:0]] = 1'b1;
      brk_armed = 1'b0;
      ext_armed = 1'b0;
      r.kind    = ps2kbt_pkg::EV_MAKE;
    end
    r.held = held_keys;
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    key_byte_t nxt;
    logic      nv;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      nv = in_valid;
      if (in_valid && in_ready) begin
        key_events_due.push_back(decode_key_byte(in_byte_valid, in_scan_byte));
        nv     = 1'b0;
        in_gap = in_calm ? 0 : $urandom_range(0, 6);
        if ($urandom_range(0, 40) == 0) in_calm = !in_calm;
      end
      if (!nv) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (byte_queue.size() > 0) begin
          nxt = byte_queue.pop_front();
          in_byte_valid <= nxt.present;
          in_scan_byte  <= nxt.code;
          nv = 1'b1;
        end
      end
      in_valid <= nv;
    end
  end

  // monitor
  always @(posedge clk) begin
    ps2kbt_pkg::result_t want;
    logic                nr;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (key_events_due.size() == 0) begin
          $error("unexpected transaction: last_byte %0h", out_last_byte);
          mismatch_count++;
        end else begin
          want = key_events_due.pop_front();
          if (out_last_byte !== want.last_byte) begin
            $error("last_byte expected %0h actual %0h", want.last_byte, out_last_byte);
            mismatch_count++;
          end
          if (out_event_kind !== want.kind) begin
            $error("event_kind expected %0d actual %0d", want.kind, out_event_kind);
            mismatch_count++;
          end
          if (out_matched_slot !== want.slot) begin
            $error("matched_slot expected %0d actual %0d", want.slot, out_matched_slot);
            mismatch_count++;
          end
          if (out_held_mask !== want.held) begin
            $error("held_mask expected %0h actual %0h", want.held, out_held_mask);
            mismatch_count++;
          end
        end
        out_gap = out_calm ? 0 : $urandom_range(0, 6);
        if ($urandom_range(0, 40) == 0) out_calm = !out_calm;
      end
      if (out_gap > 0) begin
        out_gap--;
        nr = 1'b0;
      end else begin
        nr = 1'b1;
      end
      out_ready <= nr;
    end
  end

  task automatic push_byte(input logic present, input logic [7:0] code);
    key_byte_t kb;
    kb.present = present;
    kb.code    = code;
    byte_queue.push_back(kb);
  endtask

  // make or break of a bound key, with the E0 prefix when the binding needs it
  task automatic push_key(input int k, input bit release_key);
    if (bind_ext[k]) push_byte(1'b1, ps2kbt_pkg::EXT_PREFIX);
    if (release_key) push_byte(1'b1, ps2kbt_pkg::BREAK_PREFIX);
    push_byte(1'b1, bind_codes[8*k +: 8]);
  endtask

  task automatic push_traffic(input int n);
    int start;
    int r;
    int k;
    start = byte_queue.size();
    while (byte_queue.size() - start < n) begin
      r = $urandom_range(0, 99);
      k = $urandom_range(0, ps2kbt_pkg::NUM_BINDINGS - 1);
      if (r < 42) begin
        push_key(k, 1'b0);
      end else if (r < 78) begin
        push_key(k, 1'b1);
      end else if (r < 86) begin
        push_byte(1'b1, 8'($urandom));
      end else if (r < 91) begin
        push_byte(1'b0, 8'($urandom));
      end else if (r < 95) begin
        if (bind_ext[k]) push_byte(1'b1, ps2kbt_pkg::EXT_PREFIX);
        push_byte(1'b1, ps2kbt_pkg::BREAK_PREFIX);
        push_byte(1'b1, ps2kbt_pkg::BREAK_PREFIX);
        push_byte(1'b1, bind_codes[8*k +: 8]);
      end else if (r < 98) begin
        push_byte(1'b1, ps2kbt_pkg::EXT_PREFIX);
      end else begin
        push_byte(1'b1, ps2kbt_pkg::BREAK_PREFIX);
        push_byte(1'b1, ps2kbt_pkg::EXT_PREFIX);
      end
    end
  endtask

  task automatic write_reg(input logic [ps2kbt_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ps2kbt_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ps2kbt_pkg::CFG_CODES: bind_codes = data;
      ps2kbt_pkg::CFG_EXT:   bind_ext   = data[ps2kbt_pkg::MAX_SLOTS-1:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (byte_queue.size() != 0 || in_valid || key_events_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    logic [ps2kbt_pkg::CODES_W-1:0] codes;
    logic [7:0]                     dup;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset bindings: non-extended slots low, extended slots high
    push_byte(1'b0, 8'hFF);
    push_byte(1'b1, 8'h00);
    push_byte(1'b1, 8'hFF);
    for (int k = 0; k < ps2kbt_pkg::NUM_BINDINGS; k++) push_key(k, 1'b0);
    push_byte(1'b1, ps2kbt_pkg::EXT_PREFIX);
    push_byte(1'b1, bind_codes[7:0]);
    push_key(0, 1'b1);
    push_key(4, 1'b1);
    push_byte(1'b1, ps2kbt_pkg::BREAK_PREFIX);
    push_key(1, 1'b1);
    push_byte(1'b1, ps2kbt_pkg::EXT_PREFIX);
    push_byte(1'b1, ps2kbt_pkg::BREAK_PREFIX);
    push_key(5, 1'b1);
    push_byte(1'b1, ps2kbt_pkg::BREAK_PREFIX);
    push_byte(1'b1, ps2kbt_pkg::EXT_PREFIX);
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      case (p)
        1: begin
          write_reg(ps2kbt_pkg::CFG_CODES, '0);
          write_reg(ps2kbt_pkg::CFG_EXT, '0);
          write_reg(CFG_SPARE_LO, {$urandom, $urandom});
          write_reg(CFG_SPARE_HI, '1);
        end
        2: begin
          write_reg(ps2kbt_pkg::CFG_CODES, '1);
          write_reg(ps2kbt_pkg::CFG_EXT, '1);
        end
        3: begin
          dup = 8'($urandom_range(0, 255));
          write_reg(ps2kbt_pkg::CFG_CODES, {ps2kbt_pkg::MAX_SLOTS{dup}});
          write_reg(ps2kbt_pkg::CFG_EXT, {$urandom, $urandom});
        end
        4: begin
          codes = {$urandom, $urandom};
          codes[8*$urandom_range(0, 7) +: 8] = ps2kbt_pkg::EXT_PREFIX;
          codes[8*$urandom_range(0, 7) +: 8] = ps2kbt_pkg::BREAK_PREFIX;
          codes[8*$urandom_range(4, 7) +: 8] = codes[8*$urandom_range(0, 3) +: 8];
          write_reg(ps2kbt_pkg::CFG_CODES, codes);
          write_reg(ps2kbt_pkg::CFG_EXT, {$urandom, $urandom});
        end
        5: begin
          write_reg(ps2kbt_pkg::CFG_CODES, {$urandom, $urandom});
          write_reg(ps2kbt_pkg::CFG_EXT, {$urandom, $urandom});
        end
        default: ;
      endcase
      push_traffic(265);
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

[sim.f]
src/ps2kbt_pkg.sv
src/ps2kbt_match.sv
src/ps2kbt_decode.sv
src/ps2_key_binding_tracker_top.sv
tb/tb_ps2_key_binding_tracker_top.sv
